/* rtl/spq_pkg.sv */
`default_nettype none

package spq_pkg;

   localparam int CAPACITY  = 512;
   localparam int IDX_W     = $clog2(CAPACITY);
   localparam int CNT_W     = $clog2(CAPACITY + 1);
   localparam int SYM_W     = 10;
   localparam int WGT_W     = 32;
   localparam int POS_W     = 10;
   localparam int OUT_CNT_W = 10;
   localparam int CMP_W     = (CNT_W > POS_W) ? CNT_W : POS_W;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_POP    = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;
   localparam logic [1:0] OP_CLEAR  = 2'd3;

   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_EMPTY  = 2'd1;
   localparam logic [1:0] STATUS_BADPOS = 2'd2;
   localparam logic [1:0] STATUS_FULL   = 2'd3;

   typedef struct packed {
      logic [1:0]       operation;
      logic [SYM_W-1:0] symbol;
      logic [WGT_W-1:0] weight;
      logic [POS_W-1:0] position;
   } req_word_type;

   typedef struct packed {
      logic [SYM_W-1:0]     out_symbol;
      logic [WGT_W-1:0]     out_weight;
      logic [OUT_CNT_W-1:0] entry_count;
      logic [1:0]           status;
   } rsp_word_type;

   typedef struct packed {
      logic [SYM_W-1:0] symbol;
      logic [WGT_W-1:0] weight;
   } entry_type;

   typedef struct packed {
      logic             insert_en;
      logic             pop_en;
      logic             tap_load;
      logic             tap_shift;
      entry_type        new_entry;
      logic [CNT_W-1:0] count;
   } cell_ctl_type;

endpackage

`default_nettype wire

/* rtl/spq_cell.sv */
`default_nettype none

module spq_cell (
   input  wire logic                        clock,
   input  wire logic [spq_pkg::IDX_W-1:0]   index,
   input  wire spq_pkg::cell_ctl_type       ctl,
   input  wire spq_pkg::entry_type          prev_entry,
   input  wire logic                        prev_gt,
   input  wire spq_pkg::entry_type          next_entry,
   input  wire spq_pkg::entry_type          next_tap,
   output spq_pkg::entry_type               entry,
   output logic                             gt,
   output spq_pkg::entry_type               tap
);

   localparam int CNT_W = spq_pkg::CNT_W;

   spq_pkg::entry_type entry_ff, entry_in;
   spq_pkg::entry_type tap_ff, tap_in;
   logic [CNT_W-1:0]   index_ext;
   logic               occupied;
   logic               at_end;

   assign index_ext = CNT_W'(index);
   assign occupied  = index_ext < ctl.count;
   assign at_end    = index_ext == ctl.count;
   assign gt        = occupied && (entry_ff.weight > ctl.new_entry.weight);

   always_comb begin
      entry_in = entry_ff;
      if (ctl.insert_en) begin
         if (prev_gt) begin
            entry_in = prev_entry;
         end else if (gt || at_end) begin
            entry_in = ctl.new_entry;
         end
      end else if (ctl.pop_en) begin
         entry_in = next_entry;
      end
   end

   always_comb begin
      tap_in = tap_ff;
      if (ctl.tap_load) begin
         tap_in = entry_ff;
      end else if (ctl.tap_shift) begin
         tap_in = next_tap;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      tap_ff   <= tap_in;
   end

   assign entry = entry_ff;
   assign tap   = tap_ff;

endmodule

`default_nettype wire

/* rtl/spq_ctrl.sv */
`default_nettype none

module spq_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire spq_pkg::req_word_type  req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output spq_pkg::rsp_word_type       rsp_data,
   input  wire spq_pkg::entry_type     head_entry,
   input  wire spq_pkg::entry_type     head_tap,
   output spq_pkg::cell_ctl_type       cell_ctl
);

   localparam int CNT_W     = spq_pkg::CNT_W;
   localparam int IDX_W     = spq_pkg::IDX_W;
   localparam int CMP_W     = spq_pkg::CMP_W;
   localparam int OUT_CNT_W = spq_pkg::OUT_CNT_W;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_READ = 1'b1;

   logic                  state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [IDX_W-1:0]      rd_cnt_ff, rd_cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   spq_pkg::rsp_word_type rsp_data_ff, rsp_data_in;
   logic                  accept;
   logic                  out_free;
   logic                  load_rsp;
   logic                  full;
   logic                  empty;
   logic [CMP_W-1:0]      pos_ext;
   logic [CMP_W-1:0]      count_ext;
   logic [CMP_W-1:0]      pos_m1;
   logic                  pos_bad;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !out_free;
   assign accept    = req_valid && !req_stall;

   assign full      = count_ff == CNT_W'(spq_pkg::CAPACITY);
   assign empty     = count_ff == '0;
   assign pos_ext   = CMP_W'(req_data.position);
   assign count_ext = CMP_W'(count_ff);
   assign pos_m1    = pos_ext - CMP_W'(1);
   assign pos_bad   = (pos_ext == '0) || (pos_ext > count_ext);

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      rd_cnt_in   = rd_cnt_ff;
      load_rsp    = 1'b0;
      rsp_data_in = rsp_data_ff;
      cell_ctl    = '0;
      cell_ctl.new_entry.symbol = req_data.symbol;
      cell_ctl.new_entry.weight = req_data.weight;
      cell_ctl.count            = count_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_data_in = '0;
               unique case (req_data.operation)
                  spq_pkg::OP_INSERT: begin
                     load_rsp = 1'b1;
                     if (full) begin
                        rsp_data_in.status = spq_pkg::STATUS_FULL;
                     end else begin
                        cell_ctl.insert_en = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  spq_pkg::OP_POP: begin
                     load_rsp = 1'b1;
                     if (empty) begin
                        rsp_data_in.status = spq_pkg::STATUS_EMPTY;
                     end else begin
                        cell_ctl.pop_en = 1'b1;
                        count_in = count_ff - CNT_W'(1);
                        rsp_data_in.out_symbol = head_entry.symbol;
                        rsp_data_in.out_weight = head_entry.weight;
                     end
                  end
                  spq_pkg::OP_READ: begin
                     if (pos_bad) begin
                        load_rsp = 1'b1;
                        rsp_data_in.status = spq_pkg::STATUS_BADPOS;
                     end else begin
                        cell_ctl.tap_load = 1'b1;
                        rd_cnt_in = IDX_W'(pos_m1);
                        state_in  = ST_READ;
                     end
                  end
                  spq_pkg::OP_CLEAR: begin
                     load_rsp = 1'b1;
                     count_in = '0;
                  end
                  default: begin
                     load_rsp = 1'b1;
                  end
               endcase
               rsp_data_in.entry_count = OUT_CNT_W'(count_in);
            end
         end
         ST_READ: begin
            if (rd_cnt_ff == '0) begin
               if (out_free) begin
                  load_rsp    = 1'b1;
                  rsp_data_in = '0;
                  rsp_data_in.out_symbol  = head_tap.symbol;
                  rsp_data_in.out_weight  = head_tap.weight;
                  rsp_data_in.entry_count = OUT_CNT_W'(count_ff);
                  rsp_data_in.status      = spq_pkg::STATUS_OK;
                  state_in = ST_IDLE;
               end
            end else begin
               cell_ctl.tap_shift = 1'b1;
               rd_cnt_in = rd_cnt_ff - IDX_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = load_rsp || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rd_cnt_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_cnt_ff    <= rd_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(spq_pkg::CAPACITY))
      else $error("Entry count exceeds capacity.");

   a_read_blocks: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |-> req_stall)
      else $error("A word was accepted during a positional read.");

   a_full_refused: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.operation == spq_pkg::OP_INSERT && full |=>
         rsp_valid_ff && rsp_data_ff.status == spq_pkg::STATUS_FULL && full)
      else $error("Insert into a full store was not refused.");

   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.operation == spq_pkg::OP_POP && !empty |=>
         count_ff == $past(count_ff) - CNT_W'(1))
      else $error("Remove did not lower the entry count by one.");

   a_clear_count: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.operation == spq_pkg::OP_CLEAR |=> empty)
      else $error("Clear did not empty the store.");
`endif

endmodule

`default_nettype wire

/* rtl/sorted_priority_queue_core.sv */
// Insert, remove and clear give their result word in the cycle after acceptance.
// A read at position p loads the tap chain, which then shifts the entry to the
// head cell, and no word is accepted meanwhile.
// Throughput is one word per cycle for insert, remove and clear while the result output is not stalled.
// Synchronous reset empties the store and clears the control and output valid;
// the cell contents are not reset.
`default_nettype none

module sorted_priority_queue_core (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire spq_pkg::req_word_type  req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output spq_pkg::rsp_word_type       rsp_data
);

   localparam int CAPACITY = spq_pkg::CAPACITY;
   localparam int IDX_W    = spq_pkg::IDX_W;

   spq_pkg::cell_ctl_type cell_ctl;
   spq_pkg::entry_type    entry_arr [CAPACITY];
   spq_pkg::entry_type    tap_arr   [CAPACITY];
   logic                  gt_arr    [CAPACITY];

   spq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .head_entry (entry_arr[0]),
      .head_tap   (tap_arr[0]),
      .cell_ctl   (cell_ctl)
   );

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      spq_pkg::entry_type prev_entry;
      spq_pkg::entry_type next_entry;
      spq_pkg::entry_type next_tap;
      logic               prev_gt;

      if (g == 0) begin : g_first
         assign prev_entry = '0;
         assign prev_gt    = 1'b0;
      end else begin : g_mid
         assign prev_entry = entry_arr[g-1];
         assign prev_gt    = gt_arr[g-1];
      end

      if (g == CAPACITY - 1) begin : g_last
         assign next_entry = '0;
         assign next_tap   = '0;
      end else begin : g_inner
         assign next_entry = entry_arr[g+1];
         assign next_tap   = tap_arr[g+1];
      end

      spq_cell u_cell (
         .clock      (clock),
         .index      (IDX_W'(g)),
         .ctl        (cell_ctl),
         .prev_entry (prev_entry),
         .prev_gt    (prev_gt),
         .next_entry (next_entry),
         .next_tap   (next_tap),
         .entry      (entry_arr[g]),
         .gt         (gt_arr[g]),
         .tap        (tap_arr[g])
      );
   end

endmodule

`default_nettype wire
